@@ rtl/length_prefixed_tx_fifo_slave_unit_assert.svh @@
// Assertion macros used by the transmit FIFO slave RTL.
// Depends on nothing; included by lptx_back, which checks its own logic.
`ifndef LENGTH_PREFIXED_TX_FIFO_SLAVE_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_TX_FIFO_SLAVE_UNIT_ASSERT_SVH

// Condition and consequence in the same cycle
`define LPTX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition
`define LPTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lptx_pkg.sv @@
// Package for the length-prefixed transmit FIFO slave: payload types, codes
// and default sizes. No dependencies.
`timescale 1ns / 1ps

package lptx_pkg;

   // Default sizes
   localparam int DEFAULT_STORE_DEPTH  = 128;
   localparam int DEFAULT_MAX_DATAGRAM = 32;
   // Most bytes sent by one master read
   localparam int MAX_RESULTS          = 32;
   // Reset value of the fill limit register
   localparam logic [5:0] FILL_LIMIT_RESET = 6'd63;

   // Register byte addresses
   localparam logic [1:0] ADDR_FILL_LIMIT = 2'd0;

   // Request codes
   localparam logic [1:0] REQ_HEADER = 2'd0;
   localparam logic [1:0] REQ_BYTE   = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [1:0] STATUS_RETURNED = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] length;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_byte;
      logic       last;
   } rsp_payload_type;

   // Classified command passed from front to back
   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_BYTE   = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] length;
      logic [7:0] data_byte;
   } cmd_type;

   // Head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SIZE = 2'd1,
      ST_EMIT = 2'd2
   } back_state_type;

endpackage

@@ rtl/lptx_front.sv @@
// Front end: accepts request items and classifies them into commands.
// Depends on lptx_pkg.
`timescale 1ns / 1ps

module lptx_front (
   input  logic                     start,
   input  lptx_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     busy,
   output logic                     push_valid,
   output lptx_pkg::cmd_type         push_cmd
);
   import lptx_pkg::*;

   logic accept;

   // Take an item whenever the queue has room
   assign busy   = queue_full;
   assign accept = start && !queue_full;

   // Decode the request; unknown codes are dropped without a result
   always_comb begin
      push_valid         = 1'b0;
      push_cmd.op        = OP_HEADER;
      push_cmd.length    = req_payload.length;
      push_cmd.data_byte = req_payload.data_byte;
      unique case (req_payload.req_type)
         REQ_HEADER: begin
            push_valid  = accept;
            push_cmd.op = OP_HEADER;
         end
         REQ_BYTE: begin
            push_valid  = accept;
            push_cmd.op = OP_BYTE;
         end
         REQ_READ: begin
            push_valid  = accept;
            push_cmd.op = OP_READ;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/lptx_cmd_queue.sv @@
// Two-entry command queue between the front and back ends.
// Depends on lptx_pkg.
`timescale 1ns / 1ps

module lptx_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lptx_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output logic                  full,
   output lptx_pkg::cmd_slot_type head
);
   import lptx_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_idx_ff, wr_idx_in;
   logic       rd_idx_ff, rd_idx_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_idx_ff];

   // Pointer and count update
   always_comb begin
      wr_idx_in = do_push ? ~wr_idx_ff : wr_idx_ff;
      rd_idx_in = do_pop  ? ~rd_idx_ff : rd_idx_ff;
      count_in  = count_ff;
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_idx_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/lptx_back.sv @@
// Back end: byte FIFO memory, datagram framing, drop logic and result output.
// Depends on lptx_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "length_prefixed_tx_fifo_slave_unit_assert.svh"

module lptx_back #(
   parameter int STORE_DEPTH  = lptx_pkg::DEFAULT_STORE_DEPTH,
   parameter int MAX_DATAGRAM = lptx_pkg::DEFAULT_MAX_DATAGRAM
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [5:0]                fill_limit,
   input  lptx_pkg::cmd_slot_type     head,
   output logic                      cmd_pop,
   output logic                      rsp_strobe,
   output lptx_pkg::rsp_payload_type  rsp_payload
);
   import lptx_pkg::*;

   localparam int PW = $clog2(STORE_DEPTH);
   localparam int OW = $clog2(STORE_DEPTH + 1);
   localparam int AW = $clog2(MAX_DATAGRAM + 1);
   localparam int CW = $clog2(MAX_RESULTS + 1);

   back_state_type state_ff, state_in;
   logic [PW-1:0]  rp_ff, rp_in;
   logic [PW-1:0]  wp_ff, wp_in;
   logic [OW-1:0]  occ_ff, occ_in;
   logic [AW-1:0]  ann_ff, ann_in;
   logic           drop_ff, drop_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_mem_ff, rsp_mem_in;

   logic [7:0]     mem [STORE_DEPTH];
   logic [7:0]     rd_data_ff;
   logic           rd_en;
   logic           wr_en;
   logic [7:0]     wr_data;

   logic [PW-1:0]  rp_next, wp_next;
   logic [OW:0]    hdr_need;
   logic           hdr_ok, byte_ok;
   logic [OW-1:0]  ann_ext, n_cap, n_take;
   logic           front_big, front_fits;

   // Pointer wrap at the store depth
   assign rp_next = (rp_ff == PW'(STORE_DEPTH - 1)) ? '0 : rp_ff + PW'(1);
   assign wp_next = (wp_ff == PW'(STORE_DEPTH - 1)) ? '0 : wp_ff + PW'(1);

   // Push admission checks
   assign hdr_need = {1'b0, occ_ff} + (OW+1)'(1) + (OW+1)'(head.cmd.length);
   assign hdr_ok   = (occ_ff <= OW'(fill_limit))
                  && ({1'b0, head.cmd.length} <= 7'(MAX_DATAGRAM))
                  && (hdr_need <= (OW+1)'(STORE_DEPTH));
   assign byte_ok  = !drop_ff && (occ_ff < OW'(STORE_DEPTH));

   // Payload burst length: announced, capped per read and by stored bytes
   assign ann_ext = OW'(ann_ff);
   assign n_cap   = (ann_ext > OW'(MAX_RESULTS)) ? OW'(MAX_RESULTS) : ann_ext;
   assign n_take  = (n_cap > occ_ff) ? occ_ff : n_cap;

   // Front length byte checks, from the registered memory read
   assign front_big  = rd_data_ff > 8'(MAX_DATAGRAM);
   assign front_fits = {1'b0, occ_ff} >= ((OW+1)'(rd_data_ff) + (OW+1)'(1));

   // Sequencer: next state, FIFO updates and result registers
   always_comb begin
      state_in      = state_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      occ_in        = occ_ff;
      ann_in        = ann_ff;
      drop_in       = drop_ff;
      cnt_in        = cnt_ff;
      cmd_pop       = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_data       = head.cmd.data_byte;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_RETURNED;
      rsp_byte_in   = 8'd0;
      rsp_last_in   = 1'b1;
      rsp_mem_in    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               cmd_pop = 1'b1;
               unique case (head.cmd.op)
                  OP_HEADER: begin
                     rsp_valid_in = 1'b1;
                     if (hdr_ok) begin
                        wr_en         = 1'b1;
                        wr_data       = {2'b00, head.cmd.length};
                        wp_in         = wp_next;
                        occ_in        = occ_ff + OW'(1);
                        drop_in       = 1'b0;
                        rsp_status_in = STATUS_ACCEPTED;
                     end else begin
                        drop_in       = 1'b1;
                        rsp_status_in = STATUS_DROPPED;
                     end
                  end
                  OP_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (byte_ok) begin
                        wr_en         = 1'b1;
                        wp_in         = wp_next;
                        occ_in        = occ_ff + OW'(1);
                        rsp_status_in = STATUS_ACCEPTED;
                     end else begin
                        rsp_status_in = STATUS_DROPPED;
                     end
                  end
                  OP_READ: begin
                     if (ann_ff == '0) begin
                        // Size phase: fetch the front length byte
                        if (occ_ff == '0) begin
                           rsp_valid_in = 1'b1;
                        end else begin
                           rd_en    = 1'b1;
                           state_in = ST_SIZE;
                        end
                     end else if (occ_ff == '0) begin
                        // Nothing stored: answer zero, back to size phase
                        ann_in       = '0;
                        rsp_valid_in = 1'b1;
                     end else begin
                        // Payload phase burst
                        if ((n_take < ann_ext) && (n_take == occ_ff)) begin
                           ann_in = '0;
                        end else begin
                           ann_in = AW'(ann_ext - n_take);
                        end
                        cnt_in   = CW'(n_take);
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SIZE: begin
            rsp_valid_in = 1'b1;
            priority if (front_big) begin
               // Broken framing: discard the byte
               rp_in  = rp_next;
               occ_in = occ_ff - OW'(1);
            end else if (front_fits) begin
               rp_in       = rp_next;
               occ_in      = occ_ff - OW'(1);
               ann_in      = AW'(rd_data_ff);
               rsp_byte_in = rd_data_ff;
            end
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            rd_en        = 1'b1;
            rp_in        = rp_next;
            occ_in       = occ_ff - OW'(1);
            cnt_in       = cnt_ff - CW'(1);
            rsp_valid_in = 1'b1;
            rsp_mem_in   = 1'b1;
            rsp_last_in  = (cnt_ff == CW'(1));
            if (cnt_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         occ_ff       <= '0;
         ann_ff       <= '0;
         drop_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         occ_ff       <= occ_in;
         ann_ff       <= ann_in;
         drop_ff      <= drop_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_mem_ff    <= rsp_mem_in;
   end

   // FIFO memory: one write port, one registered read port at the read pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_payload.status   = rsp_status_ff;
   assign rsp_payload.out_byte = rsp_mem_ff ? rd_data_ff : rsp_byte_ff;
   assign rsp_payload.last     = rsp_last_ff;

   // Checks
   `LPTX_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= OW'(STORE_DEPTH), "occupancy overflow")
   `LPTX_ASSERT_NOW(a_emit_has_data, clock, reset, state_ff == ST_EMIT, cnt_ff != '0 && occ_ff != '0, "burst with no data")
   `LPTX_ASSERT_NEXT(a_burst_end, clock, reset, state_ff == ST_EMIT && cnt_ff == CW'(1), rsp_valid_ff && rsp_last_ff && state_ff == ST_IDLE, "burst did not end with last")

endmodule

@@ rtl/length_prefixed_tx_fifo_slave_unit.sv @@
// Top level of the length-prefixed transmit FIFO slave: register port,
// front end, command queue and back end. Depends on lptx_pkg and the submodules.
//
// Usage:
//   Request channel: an item (req_payload) is taken at a clock edge with start
//   high and busy low. Headers and payload bytes are pushed into a byte FIFO;
//   a read request returns a datagram length (size phase) or its payload.
//   Request code 3 is ignored and gives no result.
//   Result channel: each result shows on rsp_payload for one cycle with
//   rsp_strobe high; the receiver cannot stall, so results are never held.
//   Timing: a push result is registered after its item passes the command
//   queue; a size read answers after the registered FIFO read of the length
//   byte, or without a read if the FIFO is empty; a payload read sends one byte
//   per cycle, up to 32 per read. Throughput: the back end handles one push per
//   cycle; a payload read holds it in ST_EMIT until its last byte, and a size
//   read in ST_SIZE unless empty; the registered FIFO read port sets this.
//   A two-entry command queue takes new items meanwhile; busy is high when full.
//   Register port: fill_limit at byte address 0, reset to 63; pready is tied
//   high. Reset clears pointers, occupancy, phase and drop state; the FIFO
//   memory needs no clearing since only stored bytes are read.
`timescale 1ns / 1ps

module length_prefixed_tx_fifo_slave_unit #(
   parameter int STORE_DEPTH  = lptx_pkg::DEFAULT_STORE_DEPTH,
   parameter int MAX_DATAGRAM = lptx_pkg::DEFAULT_MAX_DATAGRAM
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel
   input  logic                      start,
   output logic                      busy,
   input  lptx_pkg::req_payload_type  req_payload,
   // Result channel
   output logic                      rsp_strobe,
   output lptx_pkg::rsp_payload_type  rsp_payload,
   // Register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [1:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import lptx_pkg::*;

   logic [5:0]   fill_limit_ff, fill_limit_in;
   logic         csr_write;
   logic         queue_full;
   logic         push_valid;
   cmd_type      push_cmd;
   logic         cmd_pop;
   cmd_slot_type head;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign fill_limit_in = (csr_write && (paddr == ADDR_FILL_LIMIT)) ? pwdata[5:0]
                                                                   : fill_limit_ff;
   assign prdata = (paddr == ADDR_FILL_LIMIT) ? {26'd0, fill_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_limit_ff <= FILL_LIMIT_RESET;
      end else begin
         fill_limit_ff <= fill_limit_in;
      end
   end

   lptx_front u_front (
      .start       (start),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .busy        (busy),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   lptx_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (cmd_pop),
      .full       (queue_full),
      .head       (head)
   );

   lptx_back #(
      .STORE_DEPTH  (STORE_DEPTH),
      .MAX_DATAGRAM (MAX_DATAGRAM)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fill_limit  (fill_limit_ff),
      .head        (head),
      .cmd_pop     (cmd_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
